>>> hdl/gfad_pkg.sv
// Shared constants and types for the gamepad frame axis decoder.
`timescale 1ns / 1ps

package gfad_pkg;

  // Frame layout: switch byte, then four big-endian 16-bit axis words.
  localparam int FRAME_BYTES = 9;
  localparam int LAST_INDEX  = FRAME_BYTES - 1;
  localparam int IDX_W       = 4;

  // Axis scaling.
  localparam logic [15:0] AXIS_CENTER = 16'd511;
  localparam logic [14:0] AXIS_FULL   = 15'd16384;
  // ceil(2^32 / 511): x*2^14/511 == (x*RECIP_511) >> 18 for x < 511.
  localparam logic [23:0] RECIP_511   = 24'd8405025;
  localparam int          RECIP_SHIFT = 18;

  // Register reset values.
  localparam logic [7:0]  SYNC_BYTE_RESET     = 8'h3a;
  localparam logic [8:0]  DEADZONE_RESET      = 9'd6;
  localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd20000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SYNC_BYTE     = 2'd0,
    REG_DEADZONE      = 2'd1,
    REG_TIMEOUT_LIMIT = 2'd2
  } reg_index_t;

  // Item opcodes.
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

endpackage

>>> hdl/gfad_axis_scale.sv
// Raw 16-bit stick word to Q1.14 axis with deadzone and clamp.
`timescale 1ns / 1ps

module gfad_axis_scale (
  input  logic [15:0]        raw,
  input  logic [8:0]         deadzone,
  output logic signed [15:0] axis
);

  logic        neg;
  logic [15:0] mag;
  logic [32:0] prod;
  logic [14:0] scaled;
  logic [14:0] qm;
  logic [15:0] mag_q;

  assign neg  = raw < gfad_pkg::AXIS_CENTER;
  assign mag  = neg ? (gfad_pkg::AXIS_CENTER - raw) : (raw - gfad_pkg::AXIS_CENTER);
  // Only used while mag is below 511, where it fits in nine bits.
  assign prod   = 33'(mag[8:0]) * 33'(gfad_pkg::RECIP_511);
  assign scaled = prod[gfad_pkg::RECIP_SHIFT +: 15];

  always_comb begin
    if (mag <= {7'd0, deadzone}) begin
      qm = 15'd0;
    end else if (mag >= gfad_pkg::AXIS_CENTER) begin
      qm = gfad_pkg::AXIS_FULL;
    end else begin
      qm = scaled;
    end
  end

  assign mag_q = {1'b0, qm};
  assign axis  = $signed(neg ? (16'd0 - mag_q) : mag_q);

endmodule

>>> hdl/gamepad_frame_axis_decoder.sv
// Top level: frame parser, idle timeout and axis result register.
`timescale 1ns / 1ps

// Gamepad frame axis decoder.
// Item channel (item_valid / item_stall): one beat per received byte
// (op = byte) or idle poll tick (op = tick). A sync byte opens a frame;
// the next nine non-sync bytes are the switch byte and four big-endian
// axis words. The ninth data byte yields one result beat on the result
// channel (result_valid / result_stall) with the switches and four Q1.14
// axes. Ticks past timeout_limit yield a result with timeout_error set and
// all other fields zero, and send the parser back to hunting for sync.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 sync byte,
// 1 deadzone, 2 timeout limit; other indexes are dropped. Write it only
// while the block is idle.
// Throughput: one beat per cycle while no pending result is stalled. A
// result comes from the input register, then the parser and four
// constant-reciprocal axis scalers, combinationally into the result
// register. When result_stall holds a pending result, a full input
// register stops and item_stall rises until the result is taken.
// Reset: synchronous rst clears pipeline valids, parser state, idle count
// and restores register defaults.

module gamepad_frame_axis_decoder (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               op,
  input  logic [7:0]         rx_byte,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [7:0]         switches,
  output logic signed [15:0] axis_a_x,
  output logic signed [15:0] axis_a_y,
  output logic signed [15:0] axis_b_x,
  output logic signed [15:0] axis_b_y,
  output logic               timeout_error,
  // config channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // ---------------- configuration registers ----------------
  logic [7:0]  sync_byte;
  logic [8:0]  deadzone;
  logic [15:0] timeout_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte     <= gfad_pkg::SYNC_BYTE_RESET;
      deadzone      <= gfad_pkg::DEADZONE_RESET;
      timeout_limit <= gfad_pkg::TIMEOUT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gfad_pkg::REG_SYNC_BYTE:     sync_byte     <= cfg_data[7:0];
        gfad_pkg::REG_DEADZONE:      deadzone      <= cfg_data[8:0];
        gfad_pkg::REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;
  logic       advance;
  logic       item_accept;

  // Stage 1 moves on unless a finished result is still waiting.
  assign advance     = !result_valid || !result_stall;
  assign item_stall  = s1_valid && !advance;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_op   <= op;
      s1_byte <= rx_byte;
    end
  end

  // ---------------- parser state ----------------
  logic                      in_frame;
  logic                      in_frame_next;
  logic [gfad_pkg::IDX_W-1:0] byte_index;
  logic [gfad_pkg::IDX_W-1:0] byte_index_next;
  logic [15:0]               idle_count;
  logic [15:0]               idle_count_next;
  logic [7:0]                frame_bytes [gfad_pkg::LAST_INDEX];
  logic                      store_byte;
  logic                      frame_done;
  logic                      timeout_hit;
  logic [16:0]               idle_plus;
  logic                      fire;

  assign fire      = s1_valid && advance;
  assign idle_plus = {1'b0, idle_count} + 17'd1;

  always_comb begin
    in_frame_next   = in_frame;
    byte_index_next = byte_index;
    idle_count_next = idle_count;
    store_byte      = 1'b0;
    frame_done      = 1'b0;
    timeout_hit     = 1'b0;
    if (fire) begin
      if (s1_op == gfad_pkg::OP_TICK) begin
        if (idle_plus > {1'b0, timeout_limit}) begin
          timeout_hit     = 1'b1;
          in_frame_next   = 1'b0;
          byte_index_next = '0;
          idle_count_next = '0;
        end else begin
          idle_count_next = idle_plus[15:0];
        end
      end else if (s1_byte == sync_byte) begin
        in_frame_next   = 1'b1;
        byte_index_next = '0;
      end else if (in_frame) begin
        if (byte_index < gfad_pkg::IDX_W'(gfad_pkg::LAST_INDEX)) begin
          store_byte      = 1'b1;
          byte_index_next = byte_index + 1'b1;
        end else begin
          // ninth byte: comes straight from stage 1, not the store
          frame_done      = 1'b1;
          in_frame_next   = 1'b0;
          byte_index_next = '0;
          idle_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_index <= '0;
      idle_count <= '0;
    end else begin
      in_frame   <= in_frame_next;
      byte_index <= byte_index_next;
      idle_count <= idle_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_byte) begin
      frame_bytes[byte_index[2:0]] <= s1_byte;
    end
  end

  // ---------------- axis scaling ----------------
  logic signed [15:0] ax_a_x;
  logic signed [15:0] ax_a_y;
  logic signed [15:0] ax_b_x;
  logic signed [15:0] ax_b_y;

  gfad_axis_scale u_scale_a_x (
    .raw      ({frame_bytes[1], frame_bytes[2]}),
    .deadzone (deadzone),
    .axis     (ax_a_x)
  );

  gfad_axis_scale u_scale_a_y (
    .raw      ({frame_bytes[3], frame_bytes[4]}),
    .deadzone (deadzone),
    .axis     (ax_a_y)
  );

  gfad_axis_scale u_scale_b_x (
    .raw      ({frame_bytes[5], frame_bytes[6]}),
    .deadzone (deadzone),
    .axis     (ax_b_x)
  );

  gfad_axis_scale u_scale_b_y (
    .raw      ({frame_bytes[7], s1_byte}),
    .deadzone (deadzone),
    .axis     (ax_b_y)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= frame_done || timeout_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      switches      <= frame_bytes[0];
      axis_a_x      <= ax_a_x;
      axis_a_y      <= ax_a_y;
      axis_b_x      <= ax_b_x;
      axis_b_y      <= ax_b_y;
      timeout_error <= 1'b0;
    end else if (timeout_hit) begin
      switches      <= '0;
      axis_a_x      <= '0;
      axis_a_y      <= '0;
      axis_b_x      <= '0;
      axis_b_y      <= '0;
      timeout_error <= 1'b1;
    end
  end

  // ---------------- assertions ----------------
  a_hunt_index_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> byte_index == '0)
    else $error("byte index nonzero while hunting for sync");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> byte_index <= gfad_pkg::IDX_W'(gfad_pkg::LAST_INDEX))
    else $error("byte index past end of frame");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (frame_done || timeout_hit) |=> !in_frame && idle_count == '0 && result_valid)
    else $error("parser not cleared after result");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && timeout_error) |->
      (switches == '0 && axis_a_x == '0 && axis_a_y == '0 &&
       axis_b_x == '0 && axis_b_y == '0))
    else $error("timeout result carries nonzero fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid && result_stall))
    else $error("item channel stalled without a blocked result");

endmodule
